// ===== rtl/scoc_pkg.sv =====
package scoc_pkg;

    // Default number of depth store entries
    localparam int MAX_COLUMNS_DEF = 1024;

    // Configuration register reset value and register map
    localparam logic [10:0] SCREEN_WIDTH_RST = 11'd320;
    localparam logic        REG_SCREEN_WIDTH = 1'b0;

    // Item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CROP  = 1'b1;

    // Hint arithmetic widths
    localparam int DIV_W  = 17;
    localparam int OW_W   = 18;
    localparam int DIV_STEPS = 16;
    localparam int CNT_W  = 5;

    // Controller to datapath commands
    typedef struct packed {
        logic load_q;     // latch a crop query
        logic wr_en;      // write a column depth
        logic rd_en;      // read the depth store
        logic rd_right;   // read at the right edge (else left)
        logic step_l;     // move left edge right
        logic step_r;     // move right edge left
        logic div_start;  // start a hint division
        logic div_right;  // divide for the right hint
        logic lh_load;    // capture the left hint
        logic rh_load;    // capture the right hint
        logic out_load;   // load the output register
        logic out_vis;    // loaded item is visible
    } scoc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic off;        // sprite wholly off screen
        logic l_lt_r;     // left edge below right edge
        logic nearer;     // read wall depth is nearer than the sprite
        logic orig_pos;   // original width is positive
        logic div_done;   // divider idle with quotient ready
    } scoc_stat_t;

endpackage

// ===== rtl/scoc_divider.sv =====
// Restoring divider for the texture hints: q = floor(n * 2^16 / d), n <= d.
// First quotient bit is n >= d, then one bit per cycle.
module scoc_divider
    import scoc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic [DIV_W-1:0] quot,
    output logic             done
);

    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quot_reg, quot_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W:0]   rem_sh;
    logic             q_bit;

    // One trial subtraction per cycle
    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        rem_sh    = {rem_reg, 1'b0};
        q_bit     = 1'b0;
        if (start) begin
            q_bit     = (num >= den);
            rem_next  = q_bit ? (num - den) : num;
            quot_next = {{(DIV_W-1){1'b0}}, q_bit};
            den_next  = den;
            cnt_next  = CNT_W'(DIV_STEPS);
        end else if (cnt_reg != '0) begin
            q_bit     = (rem_sh >= {1'b0, den_reg});
            rem_next  = q_bit ? DIV_W'(rem_sh - {1'b0, den_reg}) : DIV_W'(rem_sh);
            quot_next = {quot_reg[DIV_W-2:0], q_bit};
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign quot = quot_reg;
    assign done = (cnt_reg == '0);

endmodule

// ===== rtl/scoc_datapath.sv =====
// Depth store, edge walkers, hint divider and output register.
module scoc_datapath
    import scoc_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  scoc_cmd_t   cmd,
    output scoc_stat_t  stat,
    input  logic [10:0] cfg_width,
    input  logic [9:0]  s_write_column,
    input  logic [15:0] s_wall_depth,
    input  logic [15:0] s_left_edge,
    input  logic [15:0] s_right_edge,
    input  logic [15:0] s_sprite_distance,
    output logic        m_visible,
    output logic [9:0]  m_cropped_left,
    output logic [9:0]  m_cropped_right,
    output logic [16:0] m_left_hint,
    output logic [16:0] m_right_hint
);

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int WW = AW + 1;

    logic [15:0] depth_mem [MAX_COLUMNS];

    logic [AW-1:0]    left_reg, right_reg;
    logic [DIV_W-1:0] ml_reg, mr_reg;
    logic [OW_W-1:0]  ow_reg;
    logic [15:0]      dist_reg;
    logic             off_reg;
    logic [15:0]      rdata_reg;
    logic [DIV_W-1:0] lh_reg, rh_reg;

    logic             vis_reg;
    logic [9:0]       cl_reg, cr_reg;
    logic [16:0]      olh_reg, orh_reg;

    logic [WW-1:0]    wdt;
    logic             l_ge_w, r_ge_w, off_c;
    logic [AW-1:0]    l0, r0, raddr, waddr;
    logic [DIV_W-1:0] ml0, mr0, div_num, div_q;
    logic [OW_W-1:0]  ow0;
    logic             wcol_ok, div_done;

    // Clamp the screen width and set up the edges of a new query
    always_comb begin
        if (32'(cfg_width) < 32'd2) begin
            wdt = WW'(2);
        end else if (32'(cfg_width) > 32'(MAX_COLUMNS)) begin
            wdt = WW'(MAX_COLUMNS);
        end else begin
            wdt = WW'(cfg_width);
        end
        l_ge_w = !s_left_edge[15] && (32'(s_left_edge[14:0]) >= 32'(wdt));
        r_ge_w = !s_right_edge[15] && (32'(s_right_edge[14:0]) >= 32'(wdt));
        off_c  = l_ge_w || s_right_edge[15];
        l0  = s_left_edge[15] ? '0 : AW'(s_left_edge[14:0]);
        ml0 = s_left_edge[15] ? (17'd0 - {1'b1, s_left_edge}) : '0;
        r0  = r_ge_w ? AW'(wdt - 1'b1) : AW'(s_right_edge[14:0]);
        mr0 = r_ge_w ? (17'(s_right_edge[14:0]) - 17'(wdt) + 17'd1) : '0;
        ow0 = {{2{s_right_edge[15]}}, s_right_edge}
            - {{2{s_left_edge[15]}}, s_left_edge} + 18'd1;
    end

    // Edge and count registers
    always_ff @(posedge aclk) begin
        if (cmd.load_q) begin
            left_reg  <= l0;
            right_reg <= r0;
            ml_reg    <= ml0;
            mr_reg    <= mr0;
            ow_reg    <= ow0;
            dist_reg  <= s_sprite_distance;
            off_reg   <= off_c;
        end else begin
            if (cmd.step_l) begin
                left_reg <= left_reg + 1'b1;
                ml_reg   <= ml_reg + 1'b1;
            end
            if (cmd.step_r) begin
                right_reg <= right_reg - 1'b1;
                mr_reg    <= mr_reg + 1'b1;
            end
        end
    end

    // Depth store: one write and one registered read port
    assign wcol_ok = (32'(s_write_column) < 32'(MAX_COLUMNS));
    assign waddr   = AW'(s_write_column);
    assign raddr   = cmd.rd_right ? right_reg : left_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && wcol_ok) begin
            depth_mem[waddr] <= s_wall_depth;
        end
        if (cmd.rd_en) begin
            rdata_reg <= depth_mem[raddr];
        end
    end

    // Hint divider, shared by both hints
    assign div_num = cmd.div_right ? DIV_W'(ow_reg - OW_W'(mr_reg)) : ml_reg;

    scoc_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (ow_reg[DIV_W-1:0]),
        .quot    (div_q),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.lh_load) lh_reg <= div_q;
        if (cmd.rh_load) rh_reg <= div_q;
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            vis_reg <= cmd.out_vis;
            cl_reg  <= cmd.out_vis ? 10'(left_reg) : '0;
            cr_reg  <= cmd.out_vis ? 10'(right_reg) : '0;
            olh_reg <= cmd.out_vis ? lh_reg : '0;
            orh_reg <= cmd.out_vis ? rh_reg : '0;
        end
    end

    assign m_visible       = vis_reg;
    assign m_cropped_left  = cl_reg;
    assign m_cropped_right = cr_reg;
    assign m_left_hint     = olh_reg;
    assign m_right_hint    = orh_reg;

    // Status to the controller
    assign stat.off      = off_reg;
    assign stat.l_lt_r   = (left_reg < right_reg);
    assign stat.nearer   = (rdata_reg < dist_reg);
    assign stat.orig_pos = !ow_reg[OW_W-1] && (ow_reg != '0);
    assign stat.div_done = div_done;

endmodule

// ===== rtl/scoc_ctrl.sv =====
// Sequencer for one item at a time: depth writes, edge walks, hint divisions.
module scoc_ctrl
    import scoc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_cmd,
    output logic       m_valid,
    input  logic       m_ready,
    input  scoc_stat_t stat,
    output scoc_cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_CHK  = 12'b0000_0000_0010,
        S_RDL  = 12'b0000_0000_0100,
        S_CMPL = 12'b0000_0000_1000,
        S_RDR  = 12'b0000_0001_0000,
        S_CMPR = 12'b0000_0010_0000,
        S_DLGO = 12'b0000_0100_0000,
        S_DLWT = 12'b0000_1000_0000,
        S_DRGO = 12'b0001_0000_0000,
        S_DRWT = 12'b0010_0000_0000,
        S_RES1 = 12'b0100_0000_0000,
        S_RES0 = 12'b1000_0000_0000
    } scoc_state_t;

    scoc_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        accept, out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_CROP) begin
                        cmd.load_q = 1'b1;
                        state_next = S_CHK;
                    end else begin
                        cmd.wr_en = 1'b1;
                    end
                end
            end
            S_CHK: begin
                state_next = stat.off ? S_RES0 : S_RDL;
            end
            S_RDL: begin
                cmd.rd_en  = 1'b1;
                state_next = stat.l_lt_r ? S_CMPL : S_RES0;
            end
            S_CMPL: begin
                if (stat.nearer) begin
                    cmd.step_l = 1'b1;
                    state_next = S_RDL;
                end else begin
                    state_next = S_RDR;
                end
            end
            S_RDR: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_right = 1'b1;
                state_next   = stat.l_lt_r ? S_CMPR : S_RES0;
            end
            S_CMPR: begin
                if (stat.nearer) begin
                    cmd.step_r = 1'b1;
                    state_next = S_RDR;
                end else begin
                    state_next = stat.orig_pos ? S_DLGO : S_RES0;
                end
            end
            S_DLGO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DLWT;
            end
            S_DLWT: begin
                if (stat.div_done) begin
                    cmd.lh_load = 1'b1;
                    state_next  = S_DRGO;
                end
            end
            S_DRGO: begin
                cmd.div_start = 1'b1;
                cmd.div_right = 1'b1;
                state_next    = S_DRWT;
            end
            S_DRWT: begin
                cmd.div_right = 1'b1;
                if (stat.div_done) begin
                    cmd.rh_load = 1'b1;
                    state_next  = S_RES1;
                end
            end
            S_RES1: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_vis  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_RES0: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/sprite_column_occlusion_crop_top.sv =====
// Sprite column occlusion crop. A depth write (s_cmd = 0) stores one column's
// wall depth and is taken with no result, leaving s_ready high. A crop query
// (s_cmd = 1) returns one result item: the sprite is clamped to the screen,
// then each edge walks inward past columns whose wall is nearer, and every
// step waits on the registered read of the one depth store port. The two
// texture hints come from one 17-step restoring divider used twice. After a
// query is accepted s_ready stays low until the result is loaded: after the
// off-screen check when the sprite is wholly off screen, after the walks when
// it ends hidden, and after the walks and both hint divisions when it is
// visible; the load also waits while the result register is full. Only one
// item is in work at a time; the output register lets the next item be
// accepted while a result waits. screen_width is written over the APB port at
// byte address 0 and should only change while the block is idle; depth
// entries must be written before a query can reach them.
module sprite_column_occlusion_crop_top
    import scoc_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic [9:0]         s_write_column,
    input  logic [15:0]        s_wall_depth,
    input  logic signed [15:0] s_left_edge,
    input  logic signed [15:0] s_right_edge,
    input  logic [15:0]        s_sprite_distance,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_visible,
    output logic [9:0]         m_cropped_left,
    output logic [9:0]         m_cropped_right,
    output logic [16:0]        m_left_hint,
    output logic [16:0]        m_right_hint,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [10:0] width_reg;
    logic        reg_sel;
    scoc_cmd_t   cmd;
    scoc_stat_t  stat;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_SCREEN_WIDTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= SCREEN_WIDTH_RST;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            width_reg <= pwdata[10:0];
        end
    end

    assign prdata = reg_sel ? {21'd0, width_reg} : '0;

    scoc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    scoc_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_width         (width_reg),
        .s_write_column    (s_write_column),
        .s_wall_depth      (s_wall_depth),
        .s_left_edge       (s_left_edge),
        .s_right_edge      (s_right_edge),
        .s_sprite_distance (s_sprite_distance),
        .m_visible         (m_visible),
        .m_cropped_left    (m_cropped_left),
        .m_cropped_right   (m_cropped_right),
        .m_left_hint       (m_left_hint),
        .m_right_hint      (m_right_hint)
    );

endmodule

// ===== rtl/scoc_checker.sv =====
// Port-level checks on result items.
module scoc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_visible,
    input logic [9:0]  m_cropped_left,
    input logic [9:0]  m_cropped_right,
    input logic [16:0] m_left_hint,
    input logic [16:0] m_right_hint
);

    // A hidden sprite carries an all-zero item
    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_visible |->
            m_cropped_left == 10'd0 && m_cropped_right == 10'd0 &&
            m_left_hint == 17'd0 && m_right_hint == 17'd0)
        else $error("hidden item with nonzero fields");

    // A visible sprite keeps at least two columns
    a_vis_cols: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible |-> m_cropped_left < m_cropped_right)
        else $error("visible item with edges met or crossed");

    // Texture window is nonempty and within one
    a_vis_hints: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible |->
            m_left_hint < m_right_hint && m_right_hint <= 17'h10000)
        else $error("visible item with bad texture hints");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_visible) &&
            $stable(m_cropped_left) && $stable(m_cropped_right) &&
            $stable(m_left_hint) && $stable(m_right_hint))
        else $error("result item changed while stalled");

endmodule

bind sprite_column_occlusion_crop_top scoc_checker u_scoc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_visible       (m_visible),
    .m_cropped_left  (m_cropped_left),
    .m_cropped_right (m_cropped_right),
    .m_left_hint     (m_left_hint),
    .m_right_hint    (m_right_hint)
);
